// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; clk and rst_n must exist in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define RCF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define RCF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rcf_pkg.sv =====
// types, constants and helpers for the rgb 3x3 convolution filter
// no dependencies; imported by every module of the block but rcf_ram
package rcf_pkg;

  localparam int MAX_LINE_PIXELS     = 1024;
  localparam int COEFF_FRACTION_BITS = 12;
  localparam int COEFF_W             = 18;
  localparam int CROW_W              = 3 * COEFF_W;
  localparam int COL_W               = $clog2(MAX_LINE_PIXELS);
  localparam int WIDTH_W             = 11;
  localparam int HEIGHT_W            = 12;
  localparam int ROW_W               = 12;
  localparam int PIX_W               = 24;
  localparam int LINE_W              = 2 * PIX_W;
  localparam int PROD_W              = COEFF_W + 9;
  localparam int RSUM_W              = PROD_W + 2;
  localparam int SUM_W               = RSUM_W + 2;
  localparam int FIFO_DEPTH          = 8;
  localparam int FIFO_AW             = $clog2(FIFO_DEPTH);
  localparam int CNT_W               = FIFO_AW + 1;
  localparam int CFG_IDX_W           = 3;

  localparam logic [WIDTH_W-1:0]  WIDTH_MIN     = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX     = WIDTH_W'(MAX_LINE_PIXELS);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN    = HEIGHT_W'(3);
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET   = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET  = HEIGHT_W'(480);
  localparam logic [CROW_W-1:0]   CTOP_RESET    = CROW_W'(0);
  localparam logic [CROW_W-1:0]   CMID_RESET    = CROW_W'(4096);
  localparam logic [CROW_W-1:0]   CBOT_RESET    = CROW_W'(0);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_COEFF_TOP    = 3'd2,
    CFG_COEFF_MIDDLE = 3'd3,
    CFG_COEFF_BOTTOM = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } rcf_in_t;

  typedef struct packed {
    logic [7:0] filtered_red;
    logic [7:0] filtered_green;
    logic [7:0] filtered_blue;
    logic       frame_done;
  } rcf_out_t;

  typedef logic [8:0][PIX_W-1:0] window_t;

  typedef struct packed {
    logic vld;
    logic emit;
    logic done;
  } rcf_ctl_t;

  // colour 0 red, 1 green, 2 blue
  function automatic logic [7:0] pix_chan(logic [PIX_W-1:0] p, int unsigned c);
    logic [7:0] v;
    case (c)
      0:       v = p[23:16];
      1:       v = p[15:8];
      default: v = p[7:0];
    endcase
    return v;
  endfunction

  // truncate toward zero, clamp to 0..255
  function automatic logic [7:0] saturate(logic signed [SUM_W-1:0] s);
    logic [SUM_W-1-COEFF_FRACTION_BITS:0] q;
    logic [7:0]                           r;
    q = s[SUM_W-1:COEFF_FRACTION_BITS];
    if (s <= 0) begin
      r = 8'd0;
    end else if (|q[SUM_W-1-COEFF_FRACTION_BITS:8]) begin
      r = 8'hFF;
    end else begin
      r = q[7:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/rcf_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
module rcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rcf_line_window.sv =====
// raster counters, line store ram and 3x3 window
// depends on rcf_pkg and rcf_ram
module rcf_line_window
  import rcf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  rcf_in_t             pix,
  input  logic [WIDTH_W-1:0]  frame_width,
  input  logic [HEIGHT_W-1:0] frame_height,
  input  logic                restart,
  output logic                acc_emit,
  output window_t             win,
  output rcf_ctl_t            ctl
);

  logic [COL_W-1:0]    column_count_r, column_count_nxt;
  logic [ROW_W-1:0]    row_count_r, row_count_nxt;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [COL_W-1:0]    col_cur;
  logic [WIDTH_W-1:0]  col_inc;
  logic [ROW_W:0]      row_inc;
  logic                col_wrap;
  logic                row_wrap;
  logic                acc_done;

  rcf_ctl_t            s0_ctl_r;
  logic [PIX_W-1:0]    s0_pix_r;
  logic [COL_W-1:0]    s0_col_r;
  logic [LINE_W-1:0]   rd_data;
  logic [PIX_W-1:0]    up2, up1;
  window_t             win_r;
  rcf_ctl_t            ctl_r;

  always_comb begin
    if (frame_width < WIDTH_MIN) begin
      w_eff = WIDTH_MIN;
    end else if (frame_width > WIDTH_MAX) begin
      w_eff = WIDTH_MAX;
    end else begin
      w_eff = frame_width;
    end
    h_eff = (frame_height < HEIGHT_MIN) ? HEIGHT_MIN : frame_height;
    col_cur  = ({1'b0, column_count_r} >= w_eff) ? '0 : column_count_r;
    col_inc  = {1'b0, col_cur} + WIDTH_W'(1);
    row_inc  = {1'b0, row_count_r} + (ROW_W + 1)'(1);
    col_wrap = col_inc >= w_eff;
    row_wrap = row_inc >= {1'b0, h_eff};
    acc_emit = (row_count_r >= ROW_W'(2)) && (col_cur >= COL_W'(2));
    acc_done = row_wrap && col_wrap;
  end

  always_comb begin
    column_count_nxt = column_count_r;
    row_count_nxt    = row_count_r;
    if (restart) begin
      column_count_nxt = '0;
      row_count_nxt    = '0;
    end else if (acc) begin
      if (col_wrap) begin
        column_count_nxt = '0;
        row_count_nxt    = row_wrap ? '0 : row_inc[ROW_W-1:0];
      end else begin
        column_count_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      row_count_r    <= '0;
      s0_ctl_r       <= '0;
      ctl_r          <= '0;
    end else begin
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
      s0_ctl_r       <= '{vld: acc, emit: acc_emit, done: acc_done};
      ctl_r          <= s0_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s0_pix_r <= pix;
      s0_col_r <= col_cur;
    end
  end

  // entry holds {older, newer}; read on accept, written back in the next cycle
  rcf_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_LINE_PIXELS)
  ) u_line_ram (
    .clk   (clk),
    .we    (s0_ctl_r.vld),
    .waddr (s0_col_r),
    .wdata ({up1, s0_pix_r}),
    .re    (acc),
    .raddr (col_cur),
    .rdata (rd_data)
  );

  assign up2 = rd_data[LINE_W-1:PIX_W];
  assign up1 = rd_data[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (s0_ctl_r.vld) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]     <= win_r[r*3+1];
        win_r[r*3 + 1] <= win_r[r*3+2];
      end
      win_r[2] <= up2;
      win_r[5] <= up1;
      win_r[8] <= s0_pix_r;
    end
  end

  assign win = win_r;
  assign ctl = ctl_r;

endmodule

// ===== rtl/rcf_mac.sv =====
// nine-tap multiply and sum per colour, truncation and saturation
// depends on rcf_pkg
module rcf_mac
  import rcf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  window_t           win,
  input  rcf_ctl_t          ctl,
  input  logic [CROW_W-1:0] coeffs_top,
  input  logic [CROW_W-1:0] coeffs_middle,
  input  logic [CROW_W-1:0] coeffs_bottom,
  output logic              push,
  output rcf_out_t          res
);

  logic [2:0][CROW_W-1:0]    rows;
  logic signed [PROD_W-1:0]  prod_r [3][9];
  logic signed [RSUM_W-1:0]  rsum_r [3][3];
  logic signed [SUM_W-1:0]   total  [3];
  logic [7:0]                chan_q [3];
  rcf_ctl_t                  m1_ctl_r, m2_ctl_r;

  assign rows = {coeffs_bottom, coeffs_middle, coeffs_top};

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 9; i++) begin
        prod_r[c][i] <= $signed(rows[i/3][(i%3)*COEFF_W +: COEFF_W])
                      * $signed({1'b0, pix_chan(win[i], c)});
      end
      for (int r = 0; r < 3; r++) begin
        rsum_r[c][r] <= RSUM_W'(prod_r[c][r*3]) + RSUM_W'(prod_r[c][r*3+1])
                      + RSUM_W'(prod_r[c][r*3+2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_ctl_r <= '0;
      m2_ctl_r <= '0;
    end else begin
      m1_ctl_r <= ctl;
      m2_ctl_r <= m1_ctl_r;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      total[c]  = SUM_W'(rsum_r[c][0]) + SUM_W'(rsum_r[c][1]) + SUM_W'(rsum_r[c][2]);
      chan_q[c] = saturate(total[c]);
    end
  end

  assign push = m2_ctl_r.vld && m2_ctl_r.emit;
  assign res  = '{filtered_red:   chan_q[0],
                  filtered_green: chan_q[1],
                  filtered_blue:  chan_q[2],
                  frame_done:     m2_ctl_r.done};

endmodule

// ===== rtl/rcf_out_fifo.sv =====
// result queue between the filter pipeline and the output channel
// depends on rcf_pkg
module rcf_out_fifo
  import rcf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  rcf_out_t push_data,
  input  logic     pop,
  output logic     not_empty,
  output rcf_out_t head
);

  rcf_out_t           mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = count_r != '0;
  assign head      = mem_r[rd_ptr_r];

endmodule

// ===== rtl/rgb_3x3_convolution_filter.sv =====
// top level of the rgb 3x3 convolution filter
// depends on rcf_pkg, rcf_line_window, rcf_mac, rcf_out_fifo
//
//   channel  handshake            payload
//   in       in_valid / in_stall  in_data   (rcf_in_t)
//   out      out_valid/ out_stall out_data  (rcf_out_t)
//   cfg      cfg_valid/ cfg_ready cfg_index, cfg_data
//
// one pixel per clock sustained; results pass window, product, sum and queue registers
// the line store ram (read on accept, written back the next cycle) sets that pace
// an 8-entry result queue with request credits lets the input run while out_stall is high
// in_stall rises only when 8 results are owed and not yet taken
// synchronous reset; line store contents are undefined until written, no clearing pass
module rgb_3x3_convolution_filter
  import rcf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rcf_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rcf_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CROW_W-1:0]    cfg_data
);

  logic [WIDTH_W-1:0]  frame_width_r;
  logic [HEIGHT_W-1:0] frame_height_r;
  logic [CROW_W-1:0]   coeffs_top_r, coeffs_middle_r, coeffs_bottom_r;
  logic                cfg_wr;
  logic                restart;
  logic                in_acc;
  logic                out_acc;
  logic                acc_emit;
  logic [CNT_W-1:0]    credit_r, credit_nxt;
  window_t             win;
  rcf_ctl_t            win_ctl;
  logic                push;
  rcf_out_t            push_data;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign restart   = cfg_wr && ((cfg_idx_t'(cfg_index) == CFG_FRAME_WIDTH) ||
                                (cfg_idx_t'(cfg_index) == CFG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= WIDTH_RESET;
      frame_height_r  <= HEIGHT_RESET;
      coeffs_top_r    <= CTOP_RESET;
      coeffs_middle_r <= CMID_RESET;
      coeffs_bottom_r <= CBOT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:  frame_width_r   <= cfg_data[WIDTH_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r  <= cfg_data[HEIGHT_W-1:0];
        CFG_COEFF_TOP:    coeffs_top_r    <= cfg_data;
        CFG_COEFF_MIDDLE: coeffs_middle_r <= cfg_data;
        CFG_COEFF_BOTTOM: coeffs_bottom_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = credit_r >= CNT_W'(FIFO_DEPTH);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  always_comb begin
    credit_nxt = credit_r;
    if ((in_acc && acc_emit) && !out_acc) begin
      credit_nxt = credit_r + CNT_W'(1);
    end else if (out_acc && !(in_acc && acc_emit)) begin
      credit_nxt = credit_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  rcf_line_window u_line_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (in_acc),
    .pix          (in_data),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .restart      (restart),
    .acc_emit     (acc_emit),
    .win          (win),
    .ctl          (win_ctl)
  );

  rcf_mac u_mac (
    .clk           (clk),
    .rst_n         (rst_n),
    .win           (win),
    .ctl           (win_ctl),
    .coeffs_top    (coeffs_top_r),
    .coeffs_middle (coeffs_middle_r),
    .coeffs_bottom (coeffs_bottom_r),
    .push          (push),
    .res           (push_data)
  );

  rcf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (out_acc),
    .not_empty (out_valid),
    .head      (out_data)
  );

endmodule

// ===== rtl/rcf_checker.sv =====
// port-level checker for the rgb 3x3 convolution filter, bound to the top level
// depends on rcf_pkg and assert_macros.svh
`include "assert_macros.svh"

module rcf_checker
  import rcf_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input rcf_in_t              in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input rcf_out_t             out_data,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CROW_W-1:0]    cfg_data
);

  // held result stays put
  `RCF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "out_data changed while stalled")

  // no result can come out of the pipeline right after reset
  `RCF_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_valid ##1 !out_valid ##1 !out_valid, "result too soon after reset")

  // asserts that a full credit count means results are queued; owed results may still be in the pipeline
  `RCF_ASSERT(a_stall_has_out, in_stall |-> out_valid, "input stalled with empty result queue")

  // configuration writes are never refused
  `RCF_ASSERT(a_cfg_ready, cfg_ready, "cfg_ready low")

endmodule

bind rgb_3x3_convolution_filter rcf_checker u_rcf_checker (.*);
